>>> hdl/postfix_expression_evaluator_core_defines.svh
// Assertion macros for the postfix expression evaluator.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_CORE_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_CORE_DEFINES_SVH

// The antecedent and the consequent must hold in the same cycle.
`define PFX_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("postfix evaluator check failed");

// The consequent must hold in the cycle after the antecedent.
`define PFX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("postfix evaluator check failed");

`endif

>>> hdl/pfx_eval_pkg.sv
// Token codes, error codes and arithmetic constants of the postfix evaluator.
package pfx_eval_pkg;

    localparam logic [2:0] MODE_NUMBER = 3'd0;
    localparam logic [2:0] MODE_ADD    = 3'd1;
    localparam logic [2:0] MODE_SUB    = 3'd2;
    localparam logic [2:0] MODE_MUL    = 3'd3;
    localparam logic [2:0] MODE_DIV    = 3'd4;
    localparam logic [2:0] MODE_END    = 3'd5;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_DIV_ZERO = 3'd1;
    localparam logic [2:0] ERR_MISSING  = 3'd2;
    localparam logic [2:0] ERR_EMPTY    = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW = 3'd4;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // Dividend is |left| * 2^16, a 48-bit magnitude; one quotient bit per step.
    localparam int DIV_STEPS = 48;

endpackage

>>> hdl/postfix_expression_evaluator_core.sv
// Postfix (RPN) evaluator in signed Q16.16 with its operand stack in one synchronous memory.
//
//  Channel   Signals                         Handshake
//  -------   -----------------------------   ------------------------------------------
//  token     start, mode[2:0], number[31:0]  beat taken when start is high and busy low
//  result    done, value[31:0], error[2:0]   beat shown for one cycle while done is high
//
// A number token keeps busy low. Add and subtract go through S_LOAD_L and S_EXEC, multiply
// also S_MUL_WB: the right, then the left operand is read through the single read port of the
// stack memory. Divide runs the 48-step shift-subtract divider. An end token answers in the
// cycle after the beat on an empty stack or a held error, else S_END reads the top first.
// Reset clears the count, the sticky error and the controller, not the stack memory, since
// only entries below the count are read. The receiver cannot stall: a result lasts one cycle.
`include "postfix_expression_evaluator_core_defines.svh"

module postfix_expression_evaluator_core
    import pfx_eval_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [2:0]         mode,
    input  logic signed [31:0] number,
    output logic               busy,
    output logic               done,
    output logic signed [31:0] value,
    output logic [2:0]         error
);

    // The count must hold STACK_DEPTH itself; the address only needs the entries.
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_L,
        S_EXEC,
        S_MUL_WB,
        S_DIV_RUN,
        S_DIV_WB,
        S_END
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [2:0]         err_reg, err_next;
    logic               done_reg, done_next;
    logic signed [31:0] value_reg, value_next;
    logic [2:0]         error_reg, error_next;

    // Stack memory with a registered read port.
    logic signed [31:0] stack_mem [STACK_DEPTH];
    logic signed [31:0] rd_data_reg;
    logic [AW-1:0]      rd_addr;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic signed [31:0] mem_wd;

    // Datapath registers.
    logic [2:0]         op_reg;
    logic signed [31:0] r_reg;
    logic signed [63:0] prod_reg;
    logic [31:0]        rem_reg;
    logic [47:0]        dvd_reg;
    logic [31:0]        dvs_reg;
    logic               neg_reg;
    logic [5:0]         iter_reg;

    logic [CW-1:0]      cnt_m1, cnt_m2;
    logic               accept;
    logic signed [31:0] l_val;
    logic signed [32:0] add_wide, sub_wide;
    logic signed [31:0] add_sat, sub_sat, mul_sat, div_sat;
    logic               mul_ovf;
    logic [32:0]        div_trial;
    logic [33:0]        div_diff;
    logic [31:0]        mag_l, mag_r;

    assign cnt_m1 = cnt_reg - CW'(1);
    assign cnt_m2 = cnt_reg - CW'(2);
    assign accept = start && (state_reg == S_IDLE);
    assign l_val  = rd_data_reg;

    // Saturating add and subtract on a 33-bit result.
    assign add_wide = {l_val[31], l_val} + {r_reg[31], r_reg};
    assign sub_wide = {l_val[31], l_val} - {r_reg[31], r_reg};
    assign add_sat  = (add_wide[32] != add_wide[31]) ? (add_wide[32] ? Q_MIN : Q_MAX)
                                                     : add_wide[31:0];
    assign sub_sat  = (sub_wide[32] != sub_wide[31]) ? (sub_wide[32] ? Q_MIN : Q_MAX)
                                                     : sub_wide[31:0];

    // Product bits 63:16 are the floor of the shifted value; it fits in 32 bits only
    // when bits 63:47 agree.
    assign mul_ovf = !((&prod_reg[63:47]) || !(|prod_reg[63:47]));
    assign mul_sat = mul_ovf ? (prod_reg[63] ? Q_MIN : Q_MAX) : prod_reg[47:16];

    // Restoring divider step on magnitudes; the quotient shifts into dvd_reg.
    assign div_trial = {rem_reg, dvd_reg[47]};
    assign div_diff  = {1'b0, div_trial} - {2'b00, dvs_reg};
    assign mag_l     = l_val[31] ? 32'(-l_val) : 32'(l_val);
    assign mag_r     = r_reg[31] ? 32'(-r_reg) : 32'(r_reg);

    // Quotient is truncated toward zero; saturate by sign.
    always_comb
    begin
        if (neg_reg)
        begin
            if (dvd_reg > 48'h0000_8000_0000)
                div_sat = Q_MIN;
            else
                div_sat = 32'(-dvd_reg[31:0]);
        end
        else
        begin
            if (dvd_reg > 48'h0000_7FFF_FFFF)
                div_sat = Q_MAX;
            else
                div_sat = dvd_reg[31:0];
        end
    end

    // The read port looks at the top of stack, except while fetching the left operand.
    always_comb
    begin
        if (state_reg == S_LOAD_L)
            rd_addr = cnt_m2[AW-1:0];
        else
            rd_addr = cnt_m1[AW-1:0];
    end

    // Controller: next state, stack count, sticky error, result beat and memory writes.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        err_next   = err_reg;
        done_next  = 1'b0;
        value_next = value_reg;
        error_next = error_reg;
        mem_we     = 1'b0;
        mem_wa     = cnt_reg[AW-1:0];
        mem_wd     = number;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_END)
                    begin
                        if (err_reg != ERR_NONE || cnt_reg == CW'(0))
                        begin
                            // Nothing to read: report at once and clear.
                            done_next  = 1'b1;
                            value_next = '0;
                            error_next = (err_reg != ERR_NONE) ? err_reg : ERR_EMPTY;
                            cnt_next   = '0;
                            err_next   = ERR_NONE;
                        end
                        else
                        begin
                            state_next = S_END;
                        end
                    end
                    else if (err_reg == ERR_NONE)
                    begin
                        case (mode) inside
                            MODE_NUMBER:
                            begin
                                if (cnt_reg == CW'(STACK_DEPTH))
                                begin
                                    err_next = ERR_OVERFLOW;
                                end
                                else
                                begin
                                    mem_we   = 1'b1;
                                    cnt_next = cnt_reg + CW'(1);
                                end
                            end
                            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV:
                            begin
                                if (cnt_reg < CW'(2))
                                    err_next = ERR_MISSING;
                                else
                                    state_next = S_LOAD_L;
                            end
                            default:
                            begin
                                // Unused token kinds are ignored.
                            end
                        endcase
                    end
                end
            end
            S_LOAD_L:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                mem_wa = cnt_m2[AW-1:0];
                case (op_reg)
                    MODE_ADD:
                    begin
                        mem_we     = 1'b1;
                        mem_wd     = add_sat;
                        cnt_next   = cnt_m1;
                        state_next = S_IDLE;
                    end
                    MODE_SUB:
                    begin
                        mem_we     = 1'b1;
                        mem_wd     = sub_sat;
                        cnt_next   = cnt_m1;
                        state_next = S_IDLE;
                    end
                    MODE_MUL:
                    begin
                        state_next = S_MUL_WB;
                    end
                    default:
                    begin
                        if (r_reg == 32'sd0)
                        begin
                            // Both operands are consumed, nothing is pushed.
                            err_next   = ERR_DIV_ZERO;
                            cnt_next   = cnt_m2;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_DIV_RUN;
                        end
                    end
                endcase
            end
            S_MUL_WB:
            begin
                mem_we     = 1'b1;
                mem_wa     = cnt_m2[AW-1:0];
                mem_wd     = mul_sat;
                cnt_next   = cnt_m1;
                state_next = S_IDLE;
            end
            S_DIV_RUN:
            begin
                if (iter_reg == 6'(DIV_STEPS - 1))
                    state_next = S_DIV_WB;
            end
            S_DIV_WB:
            begin
                mem_we     = 1'b1;
                mem_wa     = cnt_m2[AW-1:0];
                mem_wd     = div_sat;
                cnt_next   = cnt_m1;
                state_next = S_IDLE;
            end
            S_END:
            begin
                done_next  = 1'b1;
                value_next = rd_data_reg;
                error_next = ERR_NONE;
                cnt_next   = '0;
                err_next   = ERR_NONE;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            err_reg   <= ERR_NONE;
            done_reg  <= 1'b0;
            value_reg <= '0;
            error_reg <= ERR_NONE;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            err_reg   <= err_next;
            done_reg  <= done_next;
            value_reg <= value_next;
            error_reg <= error_next;
        end
    end

    // Operand capture, multiplier and divider registers.
    always_ff @(posedge clk)
    begin
        if (accept)
            op_reg <= mode;
        if (state_reg == S_LOAD_L)
            r_reg <= rd_data_reg;
        if (state_reg == S_EXEC)
        begin
            prod_reg <= l_val * r_reg;
            rem_reg  <= '0;
            dvd_reg  <= {mag_l, 16'h0000};
            dvs_reg  <= mag_r;
            neg_reg  <= l_val[31] ^ r_reg[31];
            iter_reg <= '0;
        end
        else if (state_reg == S_DIV_RUN)
        begin
            if (!div_diff[33])
            begin
                rem_reg <= div_diff[31:0];
                dvd_reg <= {dvd_reg[46:0], 1'b1};
            end
            else
            begin
                rem_reg <= div_trial[31:0];
                dvd_reg <= {dvd_reg[46:0], 1'b0};
            end
            iter_reg <= iter_reg + 6'd1;
        end
    end

    // Stack memory.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack_mem[mem_wa] <= mem_wd;
        rd_data_reg <= stack_mem[rd_addr];
    end

    assign busy  = (state_reg != S_IDLE);
    assign done  = done_reg;
    assign value = value_reg;
    assign error = error_reg;

    `PFX_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CW'(STACK_DEPTH))
    `PFX_ASSERT_NOW(a_done_clears, done_reg, cnt_reg == CW'(0) && err_reg == ERR_NONE)
    `PFX_ASSERT_NOW(a_err_value_zero, done_reg && error_reg != ERR_NONE, value_reg == 32'sd0)
    `PFX_ASSERT_NOW(a_div_nonzero, state_reg == S_DIV_RUN, dvs_reg != 32'd0)
    `PFX_ASSERT_NEXT(a_end_result, state_reg == S_END, done_reg && error_reg == ERR_NONE)

endmodule

>>> test/tb.sv
// Self-checking testbench for the postfix expression evaluator core.
module tb
    import pfx_eval_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH = 16;
    localparam int TOKEN_BUDGET = 1550;
    localparam int CYCLE_LIMIT = 1000000;
    // This drain window covers an end token's answer and a whole divide with room to spare.
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         error;
    } rpn_result_t;

    // Keeps a private copy of the operand stack and the sticky error, works out
    // the answer of every end token as token beats are accepted, and checks the
    // result beats against those answers in order.
    class rpn_scoreboard;
        logic signed [31:0] stack_mem [STACK_DEPTH];
        int unsigned        stack_count;
        logic [2:0]         sticky_error;
        rpn_result_t        expected_results [$];
        int unsigned        failures;

        function new();
            stack_count = 0;
            sticky_error = ERR_NONE;
            failures = 0;
        endfunction

        function logic signed [31:0] saturate(longint v);
            if (v > longint'(Q_MAX))
                return Q_MAX;
            if (v < longint'(Q_MIN))
                return Q_MIN;
            return v[31:0];
        endfunction

        function void report_failure(string what);
            failures++;
            if (failures <= 10)
                $display("%0t: %s", $realtime, what);
        endfunction

        // Applies one accepted token to the model stack.
        function void note_token(logic [2:0] tok, logic signed [31:0] num);
            rpn_result_t answer;
            longint      right_op;
            longint      left_op;
            longint      raw;
            if (tok == MODE_END)
            begin
                answer.value = '0;
                answer.error = sticky_error;
                if (sticky_error == ERR_NONE)
                begin
                    if (stack_count == 0)
                        answer.error = ERR_EMPTY;
                    else
                        answer.value = stack_mem[stack_count - 1];
                end
                expected_results.insert(expected_results.size(), answer);
                stack_count = 0;
                sticky_error = ERR_NONE;
                return;
            end
            // Unused token kinds and anything after an error change nothing.
            if (tok > MODE_END || sticky_error != ERR_NONE)
                return;
            if (tok == MODE_NUMBER)
            begin
                if (stack_count >= STACK_DEPTH)
                    sticky_error = ERR_OVERFLOW;
                else
                begin
                    stack_mem[stack_count] = num;
                    stack_count++;
                end
                return;
            end
            if (stack_count < 2)
            begin
                sticky_error = ERR_MISSING;
                return;
            end
            right_op = stack_mem[stack_count - 1];
            left_op = stack_mem[stack_count - 2];
            stack_count -= 2;
            case (tok)
                MODE_ADD: raw = left_op + right_op;
                MODE_SUB: raw = left_op - right_op;
                // Arithmetic shift of the full product rounds toward minus infinity.
                MODE_MUL: raw = (left_op * right_op) >>> 16;
                default:
                begin
                    if (right_op == 0)
                    begin
                        sticky_error = ERR_DIV_ZERO;
                        return;
                    end
                    raw = (left_op * 65536) / right_op;
                end
            endcase
            stack_mem[stack_count] = saturate(raw);
            stack_count++;
        endfunction

        function void check_result(logic signed [31:0] got_value, logic [2:0] got_error);
            rpn_result_t want;
            if (expected_results.size() == 0)
            begin
                report_failure($sformatf("unexpected result beat value=%h error=%0d",
                                         got_value, got_error));
                return;
            end
            want = expected_results.pop_front();
            if (got_value !== want.value || got_error !== want.error)
                report_failure($sformatf(
                    "mismatch: expected value=%h error=%0d, got value=%h error=%0d",
                    want.value, want.error, got_value, got_error));
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic [2:0]         mode;
    logic signed [31:0] number;
    logic               busy;
    logic               done;
    logic signed [31:0] value;
    logic [2:0]         error;

    rpn_scoreboard sb = new();
    int unsigned   tokens_sent;
    int unsigned   idle_pct;
    int unsigned   cycle_count;

    postfix_expression_evaluator_core #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (mode),
        .number (number),
        .busy   (busy),
        .done   (done),
        .value  (value),
        .error  (error)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Both sides are observed at the rising edge, before any of this edge's
    // updates land. A result beat is checked before a token beat is noted, so a
    // new end token can never be mistaken for the answer that is due now.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(value, error);
            if (start && !busy)
                sb.note_token(mode, number);
        end
    end

    // Watchdog: a run that is still going at the limit has hung.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[postfix_expression_evaluator_core] ERROR");
        $finish;
    end

    // Presents one token and holds it until the core takes the beat. Start stays
    // high into the next token unless the sender decides to idle for a while;
    // gaps are mostly short, sometimes long enough to span a whole divide.
    task automatic send_token(input logic [2:0] tok, input logic signed [31:0] num);
        start <= 1'b1;
        mode <= tok;
        number <= num;
        do
            @(posedge clk);
        while (busy);
        if (tok <= MODE_END)
            tokens_sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            mode <= 3'($urandom);
            number <= $urandom;
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(5, 60)) @(posedge clk);
            else
                repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // Operand values lean toward the corners: zero, the two saturation limits,
    // one LSB either way, small numbers with a fraction, and raw random words.
    function automatic logic signed [31:0] random_operand();
        int pick;
        pick = $urandom_range(15);
        case (pick) inside
            0: return 32'sd0;
            1: return Q_MAX;
            2: return Q_MIN;
            3: return $urandom_range(1) ? 32'sd1 : -32'sd1;
            [4:8]:
                return (int'($urandom_range(16)) - 8) * 65536 + int'($urandom_range(65535));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] random_operator();
        return 3'($urandom_range(MODE_ADD, MODE_DIV));
    endfunction

    // Emits a well-formed expression with the given number of operands. Operators
    // are only placed where two operands are on the stack, and the stack is never
    // pushed past its depth, so these expressions get all the way to the end.
    task automatic send_expression(input int unsigned operands);
        int unsigned depth;
        int unsigned pushed;
        depth = 0;
        pushed = 0;
        while (pushed < operands || depth > 1)
        begin
            if (depth >= 2 && (pushed == operands || depth == STACK_DEPTH ||
                               $urandom_range(1) == 1))
            begin
                send_token(random_operator(), random_operand());
                depth--;
            end
            else
            begin
                send_token(MODE_NUMBER, random_operand());
                depth++;
                pushed++;
            end
        end
        send_token(MODE_END, random_operand());
    endtask

    task automatic send_random_sequence();
        int unsigned kind;
        kind = $urandom_range(99);
        if (kind < 75)
        begin
            if ($urandom_range(9) == 0)
                send_expression($urandom_range(7, STACK_DEPTH + 1));
            else
                send_expression($urandom_range(1, 5));
        end
        else if (kind < 81)
        begin
            // A full stack with no overflow, or one to three numbers too many.
            repeat (STACK_DEPTH + $urandom_range(0, 3))
                send_token(MODE_NUMBER, random_operand());
            if ($urandom_range(1))
                send_token(random_operator(), random_operand());
            send_token(MODE_END, random_operand());
        end
        else if (kind < 88)
        begin
            // An operator with fewer than two operands, then some tokens that
            // the sticky error should swallow.
            repeat ($urandom_range(0, 1))
                send_token(MODE_NUMBER, random_operand());
            send_token(random_operator(), random_operand());
            repeat ($urandom_range(0, 3))
                send_token(3'($urandom_range(MODE_NUMBER, MODE_DIV)), random_operand());
            send_token(MODE_END, random_operand());
        end
        else if (kind < 92)
        begin
            send_token(MODE_END, random_operand());
        end
        else
        begin
            // Noise: any token kind, the unused ones included.
            repeat ($urandom_range(1, 8))
                send_token(3'($urandom), random_operand());
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        mode <= MODE_NUMBER;
        number <= '0;
        tokens_sent = 0;
        idle_pct = 9;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // End token on an empty stack.
        send_token(MODE_END, 32'sd0);
        // Saturation at both limits through every operator: the sum and the
        // difference clip high, the product clips low, and the most negative
        // value divided by minus one LSB clips high. An unused token kind in the
        // middle must leave the stack alone.
        send_token(MODE_NUMBER, Q_MAX);
        send_token(MODE_NUMBER, Q_MAX);
        send_token(MODE_ADD, Q_MIN);
        send_token(MODE_NUMBER, Q_MIN);
        send_token(MODE_SUB, 32'sd0);
        send_token(MODE_NUMBER, Q_MIN);
        send_token(MODE_MUL, Q_MAX);
        send_token(MODE_NUMBER, -32'sd1);
        send_token(MODE_DIV, 32'sd0);
        send_token(3'd6, Q_MAX);
        send_token(MODE_END, Q_MIN);
        // Division by zero, with a later number that the sticky error drops.
        send_token(MODE_NUMBER, 32'sd0);
        send_token(MODE_NUMBER, 32'sd0);
        send_token(MODE_DIV, 32'sd0);
        send_token(MODE_NUMBER, 32'sd5);
        send_token(MODE_END, 32'sd0);
        // Missing operand on an empty stack, followed by the other unused kind.
        send_token(MODE_ADD, 32'sd0);
        send_token(3'd7, -32'sd1);
        send_token(MODE_END, 32'sd0);

        // Random part in three stretches: light sender idling, heavy idling,
        // then back-to-back beats.
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 9 : (phase == 1) ? 79 : 0;
            while (tokens_sent < TOKEN_BUDGET * (phase + 1) / 3)
                send_random_sequence();
        end
        start <= 1'b0;

        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0)
            $display("[postfix_expression_evaluator_core] OK");
        else
            $display("[postfix_expression_evaluator_core] ERROR");
        $finish;
    end

endmodule

>>> postfix_expression_evaluator_core.f
+incdir+hdl
hdl/pfx_eval_pkg.sv
hdl/postfix_expression_evaluator_core.sv
test/tb.sv
